// ===== hw/rtl/dinucleotide_dust_score_assert.svh =====
// assertion macros, clocked on clk, reset rst
`ifndef DINUCLEOTIDE_DUST_SCORE_ASSERT_SVH
`define DINUCLEOTIDE_DUST_SCORE_ASSERT_SVH

// checked outside reset
`define DDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dds_pkg.sv =====
package dds_pkg;

  localparam int MAX_LEN_DEF       = 65536;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int NUM_BINS = 17;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam logic [BIN_W-1:0] OTHER_BIN = BIN_W'(16);

  localparam int SYM_W   = 8;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 31;
  localparam int SCORE_W = 19;
  localparam int NUM_W   = SUM_W + 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  localparam logic [2:0] CODE_A     = 3'd0;
  localparam logic [2:0] CODE_C     = 3'd1;
  localparam logic [2:0] CODE_G     = 3'd2;
  localparam logic [2:0] CODE_T     = 3'd3;
  localparam logic [2:0] CODE_OTHER = 3'd4;

  typedef struct packed {
    logic accept;
    logic load;
    logic div_step;
    logic out_load;
  } dds_cmd_t;

  typedef struct packed {
    logic last;
    logic short_seq;
    logic div_last;
  } dds_stat_t;

  function automatic logic [2:0] base_code(input logic [SYM_W-1:0] c);
    logic [2:0] code;
    unique case (c)
      "A", "a": code = CODE_A;
      "C", "c": code = CODE_C;
      "G", "g": code = CODE_G;
      "T", "t": code = CODE_T;
      default:  code = CODE_OTHER;
    endcase
    return code;
  endfunction

  function automatic logic [BIN_W-1:0] pair_bin(input logic [SYM_W-1:0] first,
                                                input logic [SYM_W-1:0] second);
    logic [2:0] a;
    logic [2:0] b;
    logic [BIN_W-1:0] bin;
    a = base_code(first);
    b = base_code(second);
    if (a == CODE_OTHER || b == CODE_OTHER) begin
      bin = OTHER_BIN;
    end else begin
      bin = BIN_W'({a[1:0], b[1:0]});
    end
    return bin;
  endfunction

endpackage

// ===== hw/rtl/dds_if.sv =====
interface dds_in_if import dds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface dds_out_if import dds_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic [SUM_W-1:0]   pair_sum;
  logic               too_long;

  modport source (output valid, output score, output pair_sum, output too_long, input ready);
  modport sink   (input valid, input score, input pair_sum, input too_long, output ready);
endinterface

// ===== hw/rtl/dinucleotide_dust_score.sv =====
// DUST-style dinucleotide low-complexity score. Characters stream in one per
// transaction on seq, one per cycle, until the transaction flagged last; each
// adjacent pair updates a 17-bin histogram and a running sum. After the last
// character seq stalls while a load state forms the length product (L-2)*L,
// while the bit-serial restoring divider runs (skipped when L<=2), and while
// a done state moves the result into the output register on res. The next
// sequence can stream in while that result waits; only a second finished
// result waits for the first to be taken, and seq stays stalled until then.
// Characters beyond MAX_LEN are dropped and reported by too_long.
module dinucleotide_dust_score import dds_pkg::*; #(
  parameter int MAX_LEN       = MAX_LEN_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  dds_in_if.sink     seq,
  dds_out_if.source  res
);

  dds_cmd_t  cmd;
  dds_stat_t stat;

  dds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq.valid),
    .in_ready  (seq.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dds_datapath #(
    .MAX_LEN       (MAX_LEN),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .symbol   (seq.symbol),
    .last     (seq.last),
    .score    (res.score),
    .pair_sum (res.pair_sum),
    .too_long (res.too_long)
  );

endmodule

// ===== hw/rtl/dds_datapath.sv =====
module dds_datapath import dds_pkg::*; #(
  parameter int MAX_LEN       = MAX_LEN_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dds_cmd_t           cmd,
  output dds_stat_t          stat,
  input  logic [SYM_W-1:0]   symbol,
  input  logic               last,
  output logic [SCORE_W-1:0] score,
  output logic [SUM_W-1:0]   pair_sum,
  output logic               too_long
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int DEN_W = 2 * LEN_W;
  localparam int DIV_W = NUM_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  logic [COUNT_W-1:0] counts [NUM_BINS];
  logic [SUM_W-1:0]   sum;
  logic [LEN_W-1:0]   length;
  logic [SYM_W-1:0]   prev;
  logic               ovf;

  logic [DIV_W-1:0]   dividend;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [SCORE_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   snap_sum;
  logic               snap_ovf;

  logic [BIN_W-1:0]   bin;
  logic [COUNT_W-1:0] cnt_rd;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic               room;
  logic               do_pair;
  logic [NUM_W-1:0]   num;
  logic [DEN_W:0]     rem_sh;
  logic               ge;

  assign bin     = pair_bin(prev, symbol);
  assign cnt_rd  = counts[bin];
  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(cnt_rd);
  assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign room    = length < LEN_W'(MAX_LEN);
  assign do_pair = cmd.accept && room && (length != '0);
  assign num     = ({4'b0, sum} << 3) + ({4'b0, sum} << 1);
  assign rem_sh  = {rem, dividend[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den};

  assign stat.last      = last;
  assign stat.short_seq = length < LEN_W'(3);
  assign stat.div_last  = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        counts[i] <= '0;
      end
    end else if (do_pair && cnt_rd != COUNT_MAX) begin
      counts[bin] <= cnt_rd + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sum    <= '0;
      length <= '0;
      ovf    <= 1'b0;
    end else if (cmd.accept) begin
      if (room) begin
        length <= length + LEN_W'(1);
        if (do_pair) begin
          sum <= sum_sat;
        end
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && room) begin
      prev <= symbol;
    end
  end

  // restoring division, one dividend bit per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend <= {num, {FRACTION_BITS{1'b0}}};
      den      <= DEN_W'(length - LEN_W'(2)) * DEN_W'(length);
      rem      <= '0;
      quo      <= '0;
      cnt      <= CNT_W'(DIV_W - 1);
      snap_sum <= sum;
      snap_ovf <= ovf;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      rem      <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quo      <= {quo[SCORE_W-2:0], ge};
      cnt      <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      score    <= quo;
      pair_sum <= snap_sum;
      too_long <= snap_ovf;
    end
  end

endmodule

// ===== hw/rtl/dds_ctrl.sv =====
`include "dinucleotide_dust_score_assert.svh"

module dds_ctrl import dds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dds_stat_t stat,
  output dds_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_RUN, ST_LOAD, ST_DIV, ST_DONE} state_t;

  state_t state;
  logic   out_free;

  assign in_ready     = state == ST_RUN;
  assign out_free     = !out_valid || out_ready;
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.load     = state == ST_LOAD;
  assign cmd.div_step = state == ST_DIV;
  assign cmd.out_load = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (cmd.accept && stat.last) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= stat.short_seq ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (stat.div_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_RUN;
          end
        end
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DDS_ASSERT(a_last_stalls, (cmd.accept && stat.last) |=> !in_ready, "input open after last")
  `DDS_ASSERT(a_load_next, cmd.load |=> (state == ST_DIV || state == ST_DONE), "bad state after load")
  `DDS_ASSERT(a_div_end, (cmd.div_step && stat.div_last) |=> (state == ST_DONE), "divider overran")
  `DDS_ASSERT(a_result_shown, cmd.out_load |=> out_valid, "result not presented")
  `DDS_ASSERT_ALWAYS(a_reset_clean, $past(rst) |-> (state == ST_RUN && !out_valid), "reset not clean")

endmodule
